[hw/rtl/chroma_bilinear_interpolator_macros.svh]
// Assertion macros shared by the chroma interpolator RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef CHROMA_BILINEAR_INTERPOLATOR_MACROS_SVH
`define CHROMA_BILINEAR_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CBI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbi assertion failed");

// Next-cycle implication, disabled during reset
`define CBI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbi assertion failed");

`endif

[hw/rtl/cbi_pkg.sv]
// Shared constants and types for the chroma bilinear interpolator.
// No dependencies; used by cbi_cell, cbi_filter and the top level.
package cbi_pkg;

   localparam int MAX_WIDTH  = 8;
   localparam int MAX_HEIGHT = 16;
   localparam int MIN_WIDTH  = 2;
   localparam int MIN_HEIGHT = 1;

   // counters hold 0..MAX_WIDTH and 0..MAX_HEIGHT
   localparam int COL_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
   localparam int TAPS   = MAX_WIDTH + 1;

   localparam int SAMPLE_W = 8;
   localparam int FRAC_W   = 3;
   localparam int WEIGHT_W = 7;   // up to 64
   localparam int PROD_W   = 14;  // 64 * 255 + 32 stays below 2^14
   localparam int SHIFT    = 6;
   localparam int ROUND    = 32;
   localparam int ONE      = 8;   // eighth-sample unit

   // config register indexes
   localparam logic [1:0] REG_X_FRAC       = 2'd0;
   localparam logic [1:0] REG_Y_FRAC       = 2'd1;
   localparam logic [1:0] REG_BLOCK_WIDTH  = 2'd2;
   localparam logic [1:0] REG_BLOCK_HEIGHT = 2'd3;

   // bilinear weights for the four neighbors
   typedef struct packed {
      logic [WEIGHT_W-1:0] wa;  // upper-left
      logic [WEIGHT_W-1:0] wb;  // upper
      logic [WEIGHT_W-1:0] wc;  // left
      logic [WEIGHT_W-1:0] wd;  // current
   } weight_type;

   // position tag that travels with a pixel
   typedef struct packed {
      logic [2:0] col;
      logic [3:0] row;
      logic       last;
   } tag_type;

endpackage

[hw/rtl/cbi_cell.sv]
// One stage of the line delay chain: holds a sample, passes it on each item.
// Depends on cbi_pkg.
module cbi_cell (
   input  logic                          clock,
   input  logic                          shift_en,
   input  logic [cbi_pkg::SAMPLE_W-1:0]  d_in,
   output logic [cbi_pkg::SAMPLE_W-1:0]  d_out
);

   logic [cbi_pkg::SAMPLE_W-1:0] sample_ff;

   // take the neighbor's sample on every accepted item
   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= d_in;
      end
   end

   assign d_out = sample_ff;

endmodule

[hw/rtl/cbi_filter.sv]
// Two-stage weighted sum: products, then sum/round into the output register.
// Depends on cbi_pkg and the assertion macro header.
`include "chroma_bilinear_interpolator_macros.svh"

module cbi_filter (
   input  logic                          clock,
   input  logic                          reset,
   input  cbi_pkg::weight_type           weight,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [cbi_pkg::SAMPLE_W-1:0]  smp_a,
   input  logic [cbi_pkg::SAMPLE_W-1:0]  smp_b,
   input  logic [cbi_pkg::SAMPLE_W-1:0]  smp_c,
   input  logic [cbi_pkg::SAMPLE_W-1:0]  smp_d,
   input  cbi_pkg::tag_type              in_tag,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [cbi_pkg::SAMPLE_W-1:0]  out_pixel,
   output cbi_pkg::tag_type              out_tag
);

   logic                        s1_valid_ff;
   logic [cbi_pkg::PROD_W-1:0]  prod_a_ff, prod_b_ff, prod_c_ff, prod_d_ff;
   cbi_pkg::tag_type            s1_tag_ff;

   logic                        out_valid_ff;
   logic [cbi_pkg::SAMPLE_W-1:0] pixel_ff;
   cbi_pkg::tag_type            out_tag_ff;

   logic                        s2_load;
   logic [cbi_pkg::PROD_W-1:0]  sum_in;

   assign s2_load  = !out_valid_ff || out_ready;
   assign in_ready = !s1_valid_ff || s2_load;

   // stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s1_valid_ff <= in_valid;
      end
   end

   // stage 1: one product per neighbor
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_a_ff <= cbi_pkg::PROD_W'(weight.wa) * cbi_pkg::PROD_W'(smp_a);
         prod_b_ff <= cbi_pkg::PROD_W'(weight.wb) * cbi_pkg::PROD_W'(smp_b);
         prod_c_ff <= cbi_pkg::PROD_W'(weight.wc) * cbi_pkg::PROD_W'(smp_c);
         prod_d_ff <= cbi_pkg::PROD_W'(weight.wd) * cbi_pkg::PROD_W'(smp_d);
         s1_tag_ff <= in_tag;
      end
   end

   // stage 2: sum, round, scale
   assign sum_in = prod_a_ff + prod_b_ff + prod_c_ff + prod_d_ff
                 + cbi_pkg::PROD_W'(cbi_pkg::ROUND);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s2_load) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         pixel_ff   <= sum_in[cbi_pkg::SHIFT +: cbi_pkg::SAMPLE_W];
         out_tag_ff <= s1_tag_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = pixel_ff;
   assign out_tag   = out_tag_ff;

   // a blocked stage 1 item is never dropped
   `CBI_ASSERT_NXT(a_s1_hold, clock, reset, s1_valid_ff && !s2_load, s1_valid_ff)
   // an item in stage 1 moves into an empty output register
   `CBI_ASSERT_NXT(a_s1_drain, clock, reset, s1_valid_ff && !out_valid_ff, out_valid_ff)
   // a pixel waiting on rsp_ stays put
   `CBI_ASSERT_NXT(a_out_hold, clock, reset, out_valid_ff && !out_ready,
                   out_valid_ff && $stable(pixel_ff))

endmodule

[hw/rtl/chroma_bilinear_interpolator.sv]
// Top level: window counters, line delay chain of cells, weights, filter pipeline.
// Depends on cbi_pkg, cbi_cell, cbi_filter and the assertion macro header.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  req_sample_in
//   rsp_      out        rsp_valid/rsp_ready  rsp_pixel_out, rsp_out_col, rsp_out_row,
//                                             rsp_block_end
//   csr_      in         csr_we               csr_index, csr_wdata
//
// One sample per cycle sustained while rsp_ is not stalled; a pixel is offered on rsp_
// after its sample passes the product register and then the output register. The
// previous row lives in a chain of MAX_WIDTH+1 cells shifted once per item; the upper
// sample is the tap at the effective width. Reset clears counters, neighbors, fractions
// and pipeline valids and sets the weights for zero fractions; the chain is not cleared.
// A stalled rsp_ stage holds req_ready low only once both pipeline registers are full.
`include "chroma_bilinear_interpolator_macros.svh"

module chroma_bilinear_interpolator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_sample_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_out,
   output logic [2:0]  rsp_out_col,
   output logic [3:0]  rsp_out_row,
   output logic        rsp_block_end,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_wdata
);

   localparam int COL_W = cbi_pkg::COL_W;
   localparam int ROW_W = cbi_pkg::ROW_W;

   // config registers
   logic [2:0] x_frac_ff, y_frac_ff;
   logic [2:0] x_frac_in, y_frac_in;
   logic [3:0] block_width_ff;
   logic [4:0] block_height_ff;

   // window state
   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [7:0]       left_ff, upper_left_ff;

   cbi_pkg::weight_type weight_ff, weight_in;

   logic [COL_W-1:0] w_eff;
   logic [ROW_W-1:0] h_eff;
   logic             accept, produce, geom_write;
   logic [7:0]       above;
   logic [7:0]       tap [cbi_pkg::TAPS];
   logic [3:0]       inv_x, inv_y;
   cbi_pkg::tag_type tag_in, rsp_tag;

   assign accept     = req_valid && req_ready;
   assign geom_write = csr_we && (csr_index == cbi_pkg::REG_BLOCK_WIDTH ||
                                  csr_index == cbi_pkg::REG_BLOCK_HEIGHT);

   // config write port
   always_ff @(posedge clock) begin
      if (reset) begin
         x_frac_ff       <= '0;
         y_frac_ff       <= '0;
         block_width_ff  <= 4'd8;
         block_height_ff <= 5'd4;
      end else if (csr_we) begin
         case (csr_index)
            cbi_pkg::REG_X_FRAC:       x_frac_ff       <= csr_wdata[2:0];
            cbi_pkg::REG_Y_FRAC:       y_frac_ff       <= csr_wdata[2:0];
            cbi_pkg::REG_BLOCK_WIDTH:  block_width_ff  <= csr_wdata[3:0];
            cbi_pkg::REG_BLOCK_HEIGHT: block_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp geometry to the supported window
   always_comb begin
      if (block_width_ff < 4'(cbi_pkg::MIN_WIDTH)) begin
         w_eff = COL_W'(cbi_pkg::MIN_WIDTH);
      end else if (block_width_ff > 4'(cbi_pkg::MAX_WIDTH)) begin
         w_eff = COL_W'(cbi_pkg::MAX_WIDTH);
      end else begin
         w_eff = COL_W'(block_width_ff);
      end
      if (block_height_ff < 5'(cbi_pkg::MIN_HEIGHT)) begin
         h_eff = ROW_W'(cbi_pkg::MIN_HEIGHT);
      end else if (block_height_ff > 5'(cbi_pkg::MAX_HEIGHT)) begin
         h_eff = ROW_W'(cbi_pkg::MAX_HEIGHT);
      end else begin
         h_eff = ROW_W'(block_height_ff);
      end
   end

   // fractions as they stand after this edge
   always_comb begin
      x_frac_in = x_frac_ff;
      y_frac_in = y_frac_ff;
      if (csr_we && csr_index == cbi_pkg::REG_X_FRAC) begin
         x_frac_in = csr_wdata[2:0];
      end
      if (csr_we && csr_index == cbi_pkg::REG_Y_FRAC) begin
         y_frac_in = csr_wdata[2:0];
      end
   end

   // weights are registered from the incoming fractions, so the next item sees them
   assign inv_x = 4'(cbi_pkg::ONE) - {1'b0, x_frac_in};
   assign inv_y = 4'(cbi_pkg::ONE) - {1'b0, y_frac_in};

   always_comb begin
      weight_in.wa = cbi_pkg::WEIGHT_W'(inv_x) * cbi_pkg::WEIGHT_W'(inv_y);
      weight_in.wb = cbi_pkg::WEIGHT_W'(x_frac_in) * cbi_pkg::WEIGHT_W'(inv_y);
      weight_in.wc = cbi_pkg::WEIGHT_W'(inv_x) * cbi_pkg::WEIGHT_W'(y_frac_in);
      weight_in.wd = cbi_pkg::WEIGHT_W'(x_frac_in) * cbi_pkg::WEIGHT_W'(y_frac_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '{wa: cbi_pkg::WEIGHT_W'(cbi_pkg::ONE * cbi_pkg::ONE),
                        wb: '0, wc: '0, wd: '0};
      end else begin
         weight_ff <= weight_in;
      end
   end

   // line delay chain: tap k holds the sample k+1 items back
   for (genvar k = 0; k < cbi_pkg::TAPS; k++) begin : g_chain
      if (k == 0) begin : g_head
         cbi_cell u_tap (
            .clock    (clock),
            .shift_en (accept),
            .d_in     (req_sample_in),
            .d_out    (tap[k])
         );
      end else begin : g_body
         cbi_cell u_tap (
            .clock    (clock),
            .shift_en (accept),
            .d_in     (tap[k-1]),
            .d_out    (tap[k])
         );
      end
   end

   // the same column one window row back
   assign above = tap[w_eff];

   // window counters
   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (geom_write) begin
         col_count_in = '0;
         row_count_in = '0;
      end else if (accept) begin
         if (col_count_ff >= w_eff) begin
            col_count_in = '0;
            row_count_in = (row_count_ff >= h_eff) ? '0 : ROW_W'(row_count_ff + 1'b1);
         end else begin
            col_count_in = COL_W'(col_count_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff  <= '0;
         row_count_ff  <= '0;
         left_ff       <= '0;
         upper_left_ff <= '0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         if (accept) begin
            left_ff       <= req_sample_in;
            upper_left_ff <= above;
         end
      end
   end

   // a pixel for every sample past the first row and column
   assign produce = (row_count_ff != '0) && (col_count_ff != '0);

   always_comb begin
      tag_in.col  = 3'(col_count_ff - 1'b1);
      tag_in.row  = 4'(row_count_ff - 1'b1);
      tag_in.last = (col_count_ff == w_eff) && (row_count_ff == h_eff);
   end

   cbi_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .weight    (weight_ff),
      .in_valid  (req_valid && produce),
      .in_ready  (req_ready),
      .smp_a     (upper_left_ff),
      .smp_b     (above),
      .smp_c     (left_ff),
      .smp_d     (req_sample_in),
      .in_tag    (tag_in),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_pixel (rsp_pixel_out),
      .out_tag   (rsp_tag)
   );

   assign rsp_out_col   = rsp_tag.col;
   assign rsp_out_row   = rsp_tag.row;
   assign rsp_block_end = rsp_tag.last;

   // counters never pass the clamped window
   `CBI_ASSERT_IMP(a_col_bound, clock, reset, 1'b1, col_count_ff <= w_eff)
   `CBI_ASSERT_IMP(a_row_bound, clock, reset, 1'b1, row_count_ff <= h_eff)
   // the last sample of a window wraps both counters
   `CBI_ASSERT_NXT(a_wrap, clock, reset,
                   accept && !geom_write && tag_in.last,
                   col_count_ff == '0 && row_count_ff == '0)

endmodule

[bench/chroma_bilinear_interpolator_checker.sv]
// Checker for the chroma bilinear interpolator: predicts each pixel from accepted samples.
// Watches the req_, rsp_ and csr_ ports; uses cbi_pkg for limits, weights and codes.
`timescale 1ns / 100ps

module chroma_bilinear_interpolator_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_sample_in,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_pixel_out,
   input  logic [2:0] rsp_out_col,
   input  logic [3:0] rsp_out_row,
   input  logic       rsp_block_end,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_wdata,
   output int         fail_count,
   output int         outstanding
);

   typedef struct {
      logic [7:0]       pixel;
      cbi_pkg::tag_type tag;
   } pixel_item_type;

   // pixels predicted but not yet seen on rsp_
   pixel_item_type expected_pixels[$];

   // mirrored window state and registers
   logic [7:0] prev_row [0:cbi_pkg::MAX_WIDTH];
   logic [7:0] left_q;
   logic [7:0] upper_left_q;
   logic [3:0] col_q;
   logic [4:0] row_q;
   logic [2:0] x_frac_q;
   logic [2:0] y_frac_q;
   logic [3:0] width_q;
   logic [4:0] height_q;

   always @(posedge clock) begin : track_window
      int             w;
      int             h;
      int             col;
      int             row;
      int             above;
      int             ul;
      int             x;
      int             y;
      int             acc;
      pixel_item_type item;
      pixel_item_type seen;

      if (reset) begin
         foreach (prev_row[i]) prev_row[i] = 8'd0;
         left_q       = 8'd0;
         upper_left_q = 8'd0;
         col_q        = 4'd0;
         row_q        = 5'd0;
         x_frac_q     = 3'd0;
         y_frac_q     = 3'd0;
         width_q      = 4'd8;
         height_q     = 5'd4;
         expected_pixels.delete();
      end else begin
         // register writes; a geometry write restarts the window
         if (csr_we) begin
            case (csr_index)
               cbi_pkg::REG_X_FRAC:       x_frac_q = csr_wdata[2:0];
               cbi_pkg::REG_Y_FRAC:       y_frac_q = csr_wdata[2:0];
               cbi_pkg::REG_BLOCK_WIDTH: begin
                  width_q = csr_wdata[3:0];
                  col_q   = 4'd0;
                  row_q   = 5'd0;
               end
               cbi_pkg::REG_BLOCK_HEIGHT: begin
                  height_q = csr_wdata;
                  col_q    = 4'd0;
                  row_q    = 5'd0;
               end
               default: ;
            endcase
         end

         // one sample in: maybe one pixel out
         if (req_valid && req_ready) begin
            w = width_q;
            if (w < cbi_pkg::MIN_WIDTH) w = cbi_pkg::MIN_WIDTH;
            if (w > cbi_pkg::MAX_WIDTH) w = cbi_pkg::MAX_WIDTH;
            h = height_q;
            if (h < cbi_pkg::MIN_HEIGHT) h = cbi_pkg::MIN_HEIGHT;
            if (h > cbi_pkg::MAX_HEIGHT) h = cbi_pkg::MAX_HEIGHT;
            col = col_q;
            row = row_q;
            if (col > w) col = w;
            above = prev_row[col];
            ul    = upper_left_q;

            if (row > 0 && col > 0) begin
               x   = x_frac_q;
               y   = y_frac_q;
               acc = (cbi_pkg::ONE - x) * (cbi_pkg::ONE - y) * ul
                   + x * (cbi_pkg::ONE - y) * above
                   + (cbi_pkg::ONE - x) * y * int'(left_q)
                   + x * y * int'(req_sample_in) + cbi_pkg::ROUND;
               item.pixel    = 8'(acc >> cbi_pkg::SHIFT);
               item.tag.col  = 3'(col - 1);
               item.tag.row  = 4'(row - 1);
               item.tag.last = (col == w && row == h);
               expected_pixels.push_back(item);
            end

            upper_left_q  = 8'(above);
            prev_row[col] = req_sample_in;
            left_q        = req_sample_in;

            if (col >= w) begin
               col_q = 4'd0;
               row_q = (row >= h) ? 5'd0 : 5'(row + 1);
            end else begin
               col_q = 4'(col + 1);
               row_q = 5'(row);
            end
         end

         // compare the pixel leaving the block with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel with none predicted: pixel_out %0d col %0d row %0d end %0d",
                      rsp_pixel_out, rsp_out_col, rsp_out_row, rsp_block_end);
               fail_count++;
            end else begin
               seen = expected_pixels.pop_front();
               if (rsp_pixel_out !== seen.pixel) begin
                  $error("pixel_out: expected %0d, actual %0d", seen.pixel, rsp_pixel_out);
                  fail_count++;
               end
               if (rsp_out_col !== seen.tag.col) begin
                  $error("out_col: expected %0d, actual %0d", seen.tag.col, rsp_out_col);
                  fail_count++;
               end
               if (rsp_out_row !== seen.tag.row) begin
                  $error("out_row: expected %0d, actual %0d", seen.tag.row, rsp_out_row);
                  fail_count++;
               end
               if (rsp_block_end !== seen.tag.last) begin
                  $error("block_end: expected %0d, actual %0d", seen.tag.last, rsp_block_end);
                  fail_count++;
               end
            end
         end
      end
      outstanding = expected_pixels.size();
   end

endmodule

[bench/chroma_bilinear_interpolator_tb.sv]
// Top of the chroma interpolator bench: clock, reset, sample stimulus, register phases.
// Depends on cbi_pkg, the block itself and chroma_bilinear_interpolator_checker.
`timescale 1ns / 100ps

module chroma_bilinear_interpolator_tb;

   localparam int SAMPLE_TARGET = 1900;
   localparam int DRAIN_CYCLES  = 8;
   localparam int STALL_LIMIT   = 1000;
   localparam int IDLE_PCT      = 21;

   // sample patterns for a run
   localparam int STYLE_RANDOM  = 0;
   localparam int STYLE_BLACK   = 1;
   localparam int STYLE_WHITE   = 2;
   localparam int STYLE_CHECKER = 3;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [7:0] req_sample_in = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic [7:0] rsp_pixel_out;
   logic [2:0] rsp_out_col;
   logic [3:0] rsp_out_row;
   logic       rsp_block_end;
   logic       csr_we        = 1'b0;
   logic [1:0] csr_index     = cbi_pkg::REG_X_FRAC;
   logic [4:0] csr_wdata     = 5'd0;

   int         fail_count;
   int         outstanding;

   // no-idle stretch flag, geometry as last written, run statistics
   logic       calm          = 1'b0;
   logic [3:0] geom_w        = 4'd8;
   logic [4:0] geom_h        = 5'd4;
   int         samples_sent  = 0;
   int         pixels_seen   = 0;
   int         reg_writes    = 0;
   int         phases        = 0;
   int         idle_cycles   = 0;

   chroma_bilinear_interpolator i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row),
      .rsp_block_end (rsp_block_end),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   chroma_bilinear_interpolator_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row),
      .rsp_block_end (rsp_block_end),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .outstanding   (outstanding)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // pixel sink with random back-pressure
   always @(negedge clock) begin
      rsp_ready <= !reset && (calm || $urandom_range(0, 99) >= IDLE_PCT);
   end

   // watchdog: cycles without any item moving
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready && !reset) pixels_seen <= pixels_seen + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: %0d cycles without an item, %0d pixels pending",
                  idle_cycles, outstanding);
         $display("chroma_bilinear_interpolator test failed");
         $finish;
      end
   end

   // one sample on req_, with random gaps; returns at a falling edge, valid still high
   task automatic send_sample(input logic [7:0] value);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      samples_sent++;
      @(negedge clock);
   endtask

   // wait until every predicted pixel is out, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // write the registers selected by mask, in index order
   task automatic program_regs(input logic [3:0] mask, input logic [4:0] xd,
                               input logic [4:0] yd, input logic [4:0] wd,
                               input logic [4:0] hd);
      logic [4:0] vals [4];
      logic [1:0] codes [4];
      vals  = '{xd, yd, wd, hd};
      codes = '{cbi_pkg::REG_X_FRAC, cbi_pkg::REG_Y_FRAC,
                cbi_pkg::REG_BLOCK_WIDTH, cbi_pkg::REG_BLOCK_HEIGHT};
      for (int i = 0; i < 4; i++) begin
         if (mask[i]) begin
            csr_we    <= 1'b1;
            csr_index <= codes[i];
            csr_wdata <= vals[i];
            @(negedge clock);
            reg_writes++;
         end
      end
      csr_we <= 1'b0;
      if (mask[2]) geom_w = wd[3:0];
      if (mask[3]) geom_h = hd;
   endtask

   // samples in one window at the current geometry
   function automatic int window_len();
      int w;
      int h;
      w = geom_w;
      if (w < cbi_pkg::MIN_WIDTH) w = cbi_pkg::MIN_WIDTH;
      if (w > cbi_pkg::MAX_WIDTH) w = cbi_pkg::MAX_WIDTH;
      h = geom_h;
      if (h < cbi_pkg::MIN_HEIGHT) h = cbi_pkg::MIN_HEIGHT;
      if (h > cbi_pkg::MAX_HEIGHT) h = cbi_pkg::MAX_HEIGHT;
      return (w + 1) * (h + 1);
   endfunction

   // a run of samples: random, flat black, flat white or a 0/255 checker;
   // stops early once the sample budget is spent
   task automatic send_run(input int count, input int style);
      logic [7:0] value;
      for (int k = 0; k < count && samples_sent < SAMPLE_TARGET; k++) begin
         case (style)
            STYLE_BLACK:   value = 8'd0;
            STYLE_WHITE:   value = 8'd255;
            STYLE_CHECKER: value = k[0] ? 8'd255 : 8'd0;
            default:       value = 8'($urandom_range(0, 255));
         endcase
         send_sample(value);
      end
   endtask

   initial begin : stimulus
      logic [3:0] mask;
      logic [4:0] xd;
      logic [4:0] yd;
      logic [4:0] wd;
      logic [4:0] hd;
      int         w_pick;
      int         roll;
      int         len;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: smallest window, zero fractions, extreme samples
      program_regs(4'b1111, 5'd0, 5'd0, 5'd2, 5'd1);
      send_run(6, STYLE_CHECKER);
      settle();

      // full fractions; width below range and height zero clamp to 2x1
      program_regs(4'b1111, 5'd7, 5'd7, 5'd1, 5'd0);
      send_run(6, STYLE_WHITE);
      settle();

      // width zero with the unused top bit set, fraction upper bits set
      program_regs(4'b1111, 5'b11111, 5'b11000, 5'b10000, 5'd1);
      send_run(6, STYLE_CHECKER);
      settle();

      // random phases
      while (samples_sent < SAMPLE_TARGET) begin
         phases++;
         calm = (samples_sent >= 700 && samples_sent < 1000);

         mask = 4'($urandom_range(0, 15));
         xd   = 5'($urandom);
         yd   = 5'($urandom);
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 2))
               0:       w_pick = 2;
               1:       w_pick = 4;
               default: w_pick = 8;
            endcase
         end else begin
            w_pick = $urandom_range(0, 15);
         end
         wd   = {1'($urandom), 4'(w_pick)};
         roll = $urandom_range(0, 9);
         if (roll < 6)      hd = 5'($urandom_range(1, 4));
         else if (roll < 9) hd = 5'($urandom_range(1, 16));
         else               hd = 5'($urandom_range(0, 31));
         program_regs(mask, xd, yd, wd, hd);

         roll = $urandom_range(0, 9);
         len  = window_len();
         if (roll < 7) begin
            // whole windows back to back
            send_run(len * $urandom_range(1, 3),
                     ($urandom_range(0, 7) == 0) ?
                        $urandom_range(STYLE_BLACK, STYLE_CHECKER) : STYLE_RANDOM);
         end else if (roll < 9) begin
            // window cut short; the next phase may restart or continue it
            send_run($urandom_range(1, len - 1), STYLE_RANDOM);
         end else begin
            // run with no regard for window borders
            send_run($urandom_range(1, 40), STYLE_RANDOM);
         end
         settle();
      end

      settle();
      $display("%0d register phases: %0d samples in, %0d pixels checked, %0d register writes",
               phases + 3, samples_sent, pixels_seen, reg_writes);
      $display("fractions 0..7, widths and heights in and out of range, cut windows");
      if (fail_count == 0) begin
         $display("chroma_bilinear_interpolator test passed");
      end else begin
         $display("chroma_bilinear_interpolator test failed");
      end
      $finish;
   end

endmodule
